FILE: hw/rtl/color_key_alpha_with_halo_top_macros.svh
// Assertion macros shared by the checker of the colour-key alpha block.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef COLOR_KEY_ALPHA_WITH_HALO_TOP_MACROS_SVH
`define COLOR_KEY_ALPHA_WITH_HALO_TOP_MACROS_SVH

// Check a property while out of reset.
`define CKAH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define CKAH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/ckah_pkg.sv
// Shared types and constants of the colour-key alpha block.
// Used by every RTL module of the block; depends on nothing.
package ckah_pkg;

  localparam int MAX_PIXELS = 262144;
  localparam int PIX_AW     = $clog2(MAX_PIXELS);
  localparam int MAX_HALO   = 15;
  localparam int HALO_W     = 4;
  localparam int COORD_W    = 10;
  localparam int ADDR_W     = 2 * COORD_W;
  localparam int TAB_W      = 5;
  localparam int TAB_LAST   = 31;
  localparam int DIV_NUM_W  = 16;
  localparam int DIV_DEN_W  = 10;

  // Item commands
  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_PROC = 2'd1,
    CMD_READ = 2'd2
  } cmd_t;

  // Register indexes
  localparam logic [2:0] REG_KEY   = 3'd0;
  localparam logic [2:0] REG_HALO  = 3'd1;
  localparam logic [2:0] REG_INC   = 3'd2;
  localparam logic [2:0] REG_WIDTH = 3'd3;
  localparam logic [2:0] REG_HGT   = 3'd4;
  localparam logic [2:0] REG_NFRM  = 3'd5;
  localparam logic [2:0] REG_FIDX  = 3'd6;

  typedef enum logic [4:0] {
    ST_IDLE, ST_READ, ST_BH_WAIT, ST_CHK, ST_K_ADDR, ST_K_RD, ST_K_WR,
    ST_TAB_START, ST_TAB_WAIT, ST_S_ADDR, ST_S_RD, ST_S_CHK,
    ST_T_ADDR, ST_T_RD, ST_T_WR, ST_DONE
  } state_t;

  typedef struct packed {
    logic [23:0] key;
    logic [3:0]  halo;
    logic [15:0] inc;
    logic [9:0]  width;
    logic [9:0]  height;
    logic [9:0]  nfrm;
    logic [8:0]  fidx;
  } cfg_t;

  typedef struct packed {
    logic acc_load;
    logic acc_read;
    logic bh_start;
    logic geo_latch;
    logic tab_init;
    logic tab_start;
    logic tab_wr;
    logic tab_next;
    logic scan_init;
    logic scan_next;
    logic addr_scan;
    logic key_wr;
    logic tgt_init;
    logic addr_tgt;
    logic tgt_wr;
    logic tgt_next;
    logic cap_read;
    logic cap_proc;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic band_empty;
    logic span_zero;
    logic scan_last;
    logic tab_last;
    logic src_ok;
    logic tgt_last;
  } dp_stat_t;

endpackage

FILE: hw/rtl/color_key_alpha_with_halo_top.sv
// Top level of the colour-key alpha block with halo: register file,
// sequencer and datapath. Depends on ckah_pkg, ckah_ctrl and ckah_dp.
//
// Usage: items enter on in_valid/in_ready. cmd load writes one RGBA pixel
// into the frame store in the accept cycle and gives no result. cmd read
// captures the addressed pixel, then raises out_valid with it (done_res 0).
// cmd process keys the selected band and, with the halo on, spreads the
// halo, then gives one result with done_res 1. With the halo on it fills,
// after keying, the 31-entry quotient table (one serial-divider run each),
// then scans the band for sources and updates every target of each source.
// Keying and halo updates are address, read and write steps on the frame
// store, which has one read port and one write port.
// One item is in work at a time; in_ready is low while an item is in work or
// its result waits on out_ready, so a stalled receiver holds the block.
// Configuration is an APB-style port with registers at byte address 4*i;
// the user must write them only while idle, which the block does not enforce.
// Reset (synchronous, rst_n low) clears the sequencer and the registers to
// their defaults; the frame store content is undefined until loaded.
module color_key_alpha_with_halo_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [17:0] in_pixel_index,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  input  logic [7:0]  in_alpha_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic [7:0]  out_alpha_out,
  output logic        out_done_res
);

  ckah_pkg::cfg_t      cfg_r, cfg_nxt;
  ckah_pkg::ctrl_cmd_t cmd;
  ckah_pkg::dp_stat_t  stat;
  logic [2:0]          reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  // Register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      unique case (reg_idx)
        ckah_pkg::REG_KEY:   cfg_nxt.key    = pwdata[23:0];
        ckah_pkg::REG_HALO:  cfg_nxt.halo   = pwdata[3:0];
        ckah_pkg::REG_INC:   cfg_nxt.inc    = pwdata[15:0];
        ckah_pkg::REG_WIDTH: cfg_nxt.width  = pwdata[9:0];
        ckah_pkg::REG_HGT:   cfg_nxt.height = pwdata[9:0];
        ckah_pkg::REG_NFRM:  cfg_nxt.nfrm   = pwdata[9:0];
        ckah_pkg::REG_FIDX:  cfg_nxt.fidx   = pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key    <= '0;
      cfg_r.halo   <= '0;
      cfg_r.inc    <= '0;
      cfg_r.width  <= 10'd320;
      cfg_r.height <= 10'd200;
      cfg_r.nfrm   <= 10'd1;
      cfg_r.fidx   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_idx)
      ckah_pkg::REG_KEY:   prdata = 32'(cfg_r.key);
      ckah_pkg::REG_HALO:  prdata = 32'(cfg_r.halo);
      ckah_pkg::REG_INC:   prdata = 32'(cfg_r.inc);
      ckah_pkg::REG_WIDTH: prdata = 32'(cfg_r.width);
      ckah_pkg::REG_HGT:   prdata = 32'(cfg_r.height);
      ckah_pkg::REG_NFRM:  prdata = 32'(cfg_r.nfrm);
      ckah_pkg::REG_FIDX:  prdata = 32'(cfg_r.fidx);
      default:             prdata = '0;
    endcase
  end

  ckah_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ckah_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .cmd            (cmd),
    .stat           (stat),
    .in_pixel_index (in_pixel_index),
    .in_red_in      (in_red_in),
    .in_green_in    (in_green_in),
    .in_blue_in     (in_blue_in),
    .in_alpha_in    (in_alpha_in),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out),
    .out_alpha_out  (out_alpha_out),
    .out_done_res   (out_done_res)
  );

endmodule

FILE: hw/rtl/ckah_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on ckah_pkg for operand widths.
module ckah_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [ckah_pkg::DIV_NUM_W-1:0]   num,
  input  logic [ckah_pkg::DIV_DEN_W-1:0]   den,
  output logic                             done,
  output logic [ckah_pkg::DIV_NUM_W-1:0]   quo
);

  localparam int CNT_W = $clog2(ckah_pkg::DIV_NUM_W + 1);

  logic [CNT_W-1:0]                 cnt_r, cnt_nxt;
  logic                             done_r, done_nxt;
  logic [ckah_pkg::DIV_NUM_W-1:0]   quo_r, quo_nxt;
  logic [ckah_pkg::DIV_DEN_W-1:0]   den_r, den_nxt;
  logic [ckah_pkg::DIV_DEN_W-1:0]   rem_r, rem_nxt;
  logic [ckah_pkg::DIV_DEN_W:0]     trial;
  logic                             ge;

  // Load the operands on start, else shift in one numerator bit and try the subtraction
  always_comb begin
    trial    = {rem_r, quo_r[ckah_pkg::DIV_NUM_W-1]};
    ge       = (trial >= {1'b0, den_r});
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt = CNT_W'(ckah_pkg::DIV_NUM_W);
      quo_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - CNT_W'(1);
      quo_nxt  = {quo_r[ckah_pkg::DIV_NUM_W-2:0], ge};
      rem_nxt  = ge ? ckah_pkg::DIV_DEN_W'(trial - {1'b0, den_r})
                    : trial[ckah_pkg::DIV_DEN_W-1:0];
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

FILE: hw/rtl/ckah_ctrl.sv
// Sequencer of the colour-key alpha block: item handshake and pass control.
// Depends on ckah_pkg for the state, command and status types.
module ckah_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [1:0]            in_cmd,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  ckah_pkg::dp_stat_t    stat,
  output ckah_pkg::ctrl_cmd_t   cmd
);

  ckah_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ckah_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ckah_pkg::ST_IDLE: begin
        in_ready = !out_valid_r;
        if (in_valid && !out_valid_r) begin
          case (in_cmd)
            ckah_pkg::CMD_LOAD: cmd.acc_load = 1'b1;
            ckah_pkg::CMD_READ: begin
              cmd.acc_read = 1'b1;
              state_nxt    = ckah_pkg::ST_READ;
            end
            ckah_pkg::CMD_PROC: begin
              cmd.bh_start = 1'b1;
              state_nxt    = ckah_pkg::ST_BH_WAIT;
            end
            default: ;
          endcase
        end
      end
      ckah_pkg::ST_READ: begin
        cmd.cap_read  = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ckah_pkg::ST_IDLE;
      end
      ckah_pkg::ST_BH_WAIT: begin
        if (stat.div_done) begin
          cmd.geo_latch = 1'b1;
          state_nxt     = ckah_pkg::ST_CHK;
        end
      end
      ckah_pkg::ST_CHK: begin
        if (stat.band_empty) begin
          state_nxt = ckah_pkg::ST_DONE;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = ckah_pkg::ST_K_ADDR;
        end
      end
      ckah_pkg::ST_K_ADDR: begin
        cmd.addr_scan = 1'b1;
        state_nxt     = ckah_pkg::ST_K_RD;
      end
      ckah_pkg::ST_K_RD: state_nxt = ckah_pkg::ST_K_WR;
      ckah_pkg::ST_K_WR: begin
        cmd.key_wr = 1'b1;
        if (!stat.scan_last) begin
          cmd.scan_next = 1'b1;
          state_nxt     = ckah_pkg::ST_K_ADDR;
        end else if (stat.span_zero) begin
          state_nxt = ckah_pkg::ST_DONE;
        end else begin
          cmd.tab_init = 1'b1;
          state_nxt    = ckah_pkg::ST_TAB_START;
        end
      end
      ckah_pkg::ST_TAB_START: begin
        cmd.tab_start = 1'b1;
        state_nxt     = ckah_pkg::ST_TAB_WAIT;
      end
      ckah_pkg::ST_TAB_WAIT: begin
        if (stat.div_done) begin
          cmd.tab_wr = 1'b1;
          if (stat.tab_last) begin
            cmd.scan_init = 1'b1;
            state_nxt     = ckah_pkg::ST_S_ADDR;
          end else begin
            cmd.tab_next = 1'b1;
            state_nxt    = ckah_pkg::ST_TAB_START;
          end
        end
      end
      ckah_pkg::ST_S_ADDR: begin
        cmd.addr_scan = 1'b1;
        state_nxt     = ckah_pkg::ST_S_RD;
      end
      ckah_pkg::ST_S_RD: state_nxt = ckah_pkg::ST_S_CHK;
      ckah_pkg::ST_S_CHK: begin
        if (stat.src_ok) begin
          cmd.tgt_init = 1'b1;
          state_nxt    = ckah_pkg::ST_T_ADDR;
        end else if (stat.scan_last) begin
          state_nxt = ckah_pkg::ST_DONE;
        end else begin
          cmd.scan_next = 1'b1;
          state_nxt     = ckah_pkg::ST_S_ADDR;
        end
      end
      ckah_pkg::ST_T_ADDR: begin
        cmd.addr_tgt = 1'b1;
        state_nxt    = ckah_pkg::ST_T_RD;
      end
      ckah_pkg::ST_T_RD: state_nxt = ckah_pkg::ST_T_WR;
      ckah_pkg::ST_T_WR: begin
        cmd.tgt_wr = 1'b1;
        if (!stat.tgt_last) begin
          cmd.tgt_next = 1'b1;
          state_nxt    = ckah_pkg::ST_T_ADDR;
        end else if (stat.scan_last) begin
          state_nxt = ckah_pkg::ST_DONE;
        end else begin
          cmd.scan_next = 1'b1;
          state_nxt     = ckah_pkg::ST_S_ADDR;
        end
      end
      ckah_pkg::ST_DONE: begin
        cmd.cap_proc  = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ckah_pkg::ST_IDLE;
      end
      default: state_nxt = ckah_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hw/rtl/ckah_dp.sv
// Datapath: frame store, band geometry, scan counters, quotient table, output.
// Depends on ckah_pkg and instantiates ckah_div.
module ckah_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ckah_pkg::cfg_t                cfg,
  input  ckah_pkg::ctrl_cmd_t           cmd,
  output ckah_pkg::dp_stat_t            stat,
  input  logic [17:0]                   in_pixel_index,
  input  logic [7:0]                    in_red_in,
  input  logic [7:0]                    in_green_in,
  input  logic [7:0]                    in_blue_in,
  input  logic [7:0]                    in_alpha_in,
  output logic [7:0]                    out_red_out,
  output logic [7:0]                    out_green_out,
  output logic [7:0]                    out_blue_out,
  output logic [7:0]                    out_alpha_out,
  output logic                          out_done_res
);

  localparam int CW = ckah_pkg::COORD_W;
  localparam int AW = ckah_pkg::ADDR_W;
  localparam int PW = ckah_pkg::PIX_AW;
  localparam int TW = ckah_pkg::TAB_W;

  // Frame store
  logic [31:0]   mem_r [0:ckah_pkg::MAX_PIXELS-1];
  logic [31:0]   rd_data_r;
  logic [PW-1:0] rd_addr, wr_addr;
  logic [31:0]   wr_data;
  logic          wr_en;

  // Geometry and counters
  logic [CW-1:0]  top_r, bot_r;
  logic [ckah_pkg::HALO_W-1:0] span_r;
  logic           empty_r;
  logic [CW-1:0]  y_r, x_r, ox_r, oy_r, tx_r, ty_r, xs_r, xe_r, ye_r;
  logic [AW-1:0]  addr_r;
  logic [7:0]     q_r;
  logic [TW-1:0]  tab_i_r;
  logic [7:0]     qtab_r [0:ckah_pkg::TAB_LAST];

  logic [CW-1:0]  fh, top_c, bot_c, mul_y, mul_x, wm1, bm1;
  logic [18:0]    top_full;
  logic [CW:0]    bot_sum, x_hi, y_hi, y_lo_lim;
  logic [CW-1:0]  dx, dy;
  logic [5:0]     wgt_idx;
  logic           in_store;
  logic [23:0]    rgb;
  logic [7:0]     alpha;
  logic [8:0]     a_sum;

  // Divider shared by band height and quotient table
  logic                           div_done;
  logic [ckah_pkg::DIV_NUM_W-1:0] div_num, div_quo;
  logic [ckah_pkg::DIV_DEN_W-1:0] div_den;

  assign div_num = cmd.tab_start ? cfg.inc : ckah_pkg::DIV_NUM_W'(cfg.height);
  assign div_den = cmd.tab_start ? ckah_pkg::DIV_DEN_W'(tab_i_r) : cfg.nfrm;

  ckah_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.bh_start | cmd.tab_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Band bounds from the band height
  always_comb begin
    fh       = (cfg.nfrm == '0) ? '0 : div_quo[CW-1:0];
    top_full = cfg.fidx * fh;
    top_c    = (top_full > 19'(cfg.height)) ? cfg.height : top_full[CW-1:0];
    bot_sum  = {1'b0, top_c} + {1'b0, fh};
    bot_c    = (bot_sum > {1'b0, cfg.height}) ? cfg.height : bot_sum[CW-1:0];
  end

  assign wm1   = cfg.width - CW'(1);
  assign bm1   = bot_r - CW'(1);
  assign mul_y = cmd.addr_tgt ? ty_r : y_r;
  assign mul_x = cmd.addr_tgt ? tx_r : x_r;

  // Diamond distance weight of the current target
  always_comb begin
    dx      = (ox_r > tx_r) ? ox_r - tx_r : tx_r - ox_r;
    dy      = (oy_r > ty_r) ? oy_r - ty_r : ty_r - oy_r;
    wgt_idx = 6'({span_r, 1'b1}) - 6'(dx) - 6'(dy);
  end

  // Clipped square around the source
  always_comb begin
    x_hi     = {1'b0, x_r} + (CW + 1)'(span_r);
    y_hi     = {1'b0, y_r} + (CW + 1)'(span_r);
    y_lo_lim = {1'b0, top_r} + (CW + 1)'(span_r);
  end

  assign in_store = (addr_r < AW'(ckah_pkg::MAX_PIXELS));
  assign rgb      = rd_data_r[23:0];
  assign alpha    = rd_data_r[31:24];
  assign a_sum    = {1'b0, alpha} + {1'b0, q_r};

  always_ff @(posedge clk) begin
    if (cmd.geo_latch) begin
      top_r   <= top_c;
      bot_r   <= bot_c;
      empty_r <= (top_c >= bot_c) || (cfg.width == '0);
      span_r  <= (32'(cfg.halo) > ckah_pkg::MAX_HALO) ?
                 ckah_pkg::HALO_W'(ckah_pkg::MAX_HALO) : cfg.halo;
    end
    // Start or advance the band scan
    if (cmd.scan_init) begin
      y_r <= top_r;
      x_r <= '0;
    end else if (cmd.scan_next) begin
      if (x_r == wm1) begin
        x_r <= '0;
        y_r <= y_r + CW'(1);
      end else begin
        x_r <= x_r + CW'(1);
      end
    end
    if (cmd.addr_scan || cmd.addr_tgt) addr_r <= AW'(mul_y) * cfg.width + AW'(mul_x);
    if (cmd.addr_tgt) q_r <= qtab_r[wgt_idx[TW-1:0]];
    // Quotient table, saturated to an alpha step
    if (cmd.tab_init) tab_i_r <= TW'(1);
    else if (cmd.tab_next) tab_i_r <= tab_i_r + TW'(1);
    if (cmd.tab_wr) qtab_r[tab_i_r] <= (div_quo > 16'd255) ? 8'd255 : div_quo[7:0];
    // Source window
    if (cmd.tgt_init) begin
      ox_r <= x_r;
      oy_r <= y_r;
      xs_r <= (x_r > CW'(span_r)) ? x_r - CW'(span_r) : '0;
      tx_r <= (x_r > CW'(span_r)) ? x_r - CW'(span_r) : '0;
      xe_r <= (x_hi > {1'b0, wm1}) ? wm1 : x_hi[CW-1:0];
      ty_r <= ({1'b0, y_r} >= y_lo_lim) ? y_r - CW'(span_r) : top_r;
      ye_r <= (y_hi > {1'b0, bm1}) ? bm1 : y_hi[CW-1:0];
    end else if (cmd.tgt_next) begin
      if (tx_r == xe_r) begin
        tx_r <= xs_r;
        ty_r <= ty_r + CW'(1);
      end else begin
        tx_r <= tx_r + CW'(1);
      end
    end
  end

  // Store write port: load, key or halo update
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_r[PW-1:0];
    wr_data = {8'd0, rgb};
    if (cmd.acc_load) begin
      wr_en   = 1'b1;
      wr_addr = in_pixel_index;
      wr_data = {in_alpha_in, in_red_in, in_green_in, in_blue_in};
    end else if (cmd.key_wr) begin
      wr_en = in_store && (rgb == cfg.key);
    end else if (cmd.tgt_wr) begin
      wr_en   = in_store && (alpha != 8'd255);
      wr_data = {(a_sum[8] ? 8'd255 : a_sum[7:0]), rgb};
    end
  end

  assign rd_addr = cmd.acc_read ? in_pixel_index : addr_r[PW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    rd_data_r <= mem_r[rd_addr];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.cap_read) begin
      out_red_out   <= rd_data_r[23:16];
      out_green_out <= rd_data_r[15:8];
      out_blue_out  <= rd_data_r[7:0];
      out_alpha_out <= rd_data_r[31:24];
      out_done_res  <= 1'b0;
    end else if (cmd.cap_proc) begin
      out_red_out   <= '0;
      out_green_out <= '0;
      out_blue_out  <= '0;
      out_alpha_out <= '0;
      out_done_res  <= 1'b1;
    end
  end

  assign stat.div_done   = div_done;
  assign stat.band_empty = empty_r;
  assign stat.span_zero  = (span_r == '0);
  assign stat.scan_last  = (x_r == wm1) && (y_r == bm1);
  assign stat.tab_last   = (tab_i_r == TW'(ckah_pkg::TAB_LAST));
  assign stat.src_ok     = in_store && (rgb != cfg.key);
  assign stat.tgt_last   = (tx_r == xe_r) && (ty_r == ye_r);

endmodule

FILE: hw/rtl/ckah_checker.sv
// Port-level checks of the colour-key alpha block, bound to the top level.
// Depends on color_key_alpha_with_halo_top_macros.svh.
`include "color_key_alpha_with_halo_top_macros.svh"

module ckah_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red_out,
  input logic [7:0] out_alpha_out,
  input logic       out_done_res
);

  logic [16:0] out_pay;

  assign out_pay = {out_red_out, out_alpha_out, out_done_res};

  // Hold a stalled result
  `CKAH_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "stalled result dropped")

  // Keep the red, alpha and done_res fields of a stalled result
  `CKAH_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_pay), "stalled result changed")

  // Take no item while a result waits
  `CKAH_ASSERT(a_no_overlap, in_ready |-> !out_valid, "item taken while result pending")

  // Drop valid after a result is taken
  `CKAH_ASSERT(a_single, out_valid && out_ready |=> !out_valid, "result repeated")

  // Come out of reset with no result
  `CKAH_ASSERT_ALWAYS(a_reset, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind color_key_alpha_with_halo_top ckah_checker u_ckah_checker (.*);

FILE: verif/color_key_alpha_with_halo_top_tb.sv
// Self-checking testbench of the colour-key alpha block with halo.
// Drives pixel items and APB register writes, and predicts each result on
// its own copy of the frame store. Depends on ckah_pkg and the top level.
module color_key_alpha_with_halo_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ckah_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 6000000;
  localparam int STORE_DEPTH = 262144;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       done;
  } pix_res_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [17:0] idx;
    logic [7:0]  r, g, b, a;
    bit          typed;
    pix_res_t    res;
  } stim_row_t;

  logic clk, rst_n;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid, in_ready, out_valid, out_ready, out_done_res;
  logic [1:0] in_cmd;
  logic [17:0] in_pixel_index;
  logic [7:0] in_red_in, in_green_in, in_blue_in, in_alpha_in;
  logic [7:0] out_red_out, out_green_out, out_blue_out, out_alpha_out;

  // Predictor state: store, written set and register copies
  logic [31:0] pix_mem [int];
  bit written [int];
  int written_q [$];
  logic [23:0] key_rgb;
  logic [3:0] halo_r;
  logic [15:0] halo_inc;
  int img_w, img_h, n_bands, band_sel;

  pix_res_t pending_q [$];
  int err_cnt;
  int snd_pct, rcv_pct;
  int hold_req, hold_seen, hold_cnt;
  longint cycles;

  color_key_alpha_with_halo_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("color_key_alpha_with_halo_top_tb: errors");
      $finish;
    end
  end

  task automatic report(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  // Check each result item against the oldest expectation
  always @(posedge clk) begin
    pix_res_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_red_out, out_green_out, out_blue_out, out_alpha_out, out_done_res};
      if (pending_q.size() == 0) begin
        report("result item with nothing expected");
      end else begin
        want = pending_q.pop_front();
        if (got.red !== want.red)
          report($sformatf("red %0h want %0h", got.red, want.red));
        if (got.green !== want.green)
          report($sformatf("green %0h want %0h", got.green, want.green));
        if (got.blue !== want.blue)
          report($sformatf("blue %0h want %0h", got.blue, want.blue));
        if (got.alpha !== want.alpha)
          report($sformatf("alpha %0h want %0h", got.alpha, want.alpha));
        if (got.done !== want.done)
          report($sformatf("done_res %0b want %0b", got.done, want.done));
      end
    end
  end

  // Drive out_ready; hold it low for a long stretch on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_cnt = 300;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rcv_pct);
    end
  end

  // Key the band, then spread halo alpha from every source
  task automatic process_band();
    int fh, top, bottom, span, idx, xs, xf, ys, yf, dx, dy, dv, t, a;
    bit src [int];
    fh = (n_bands != 0) ? img_h / n_bands : 0;
    top = band_sel * fh;
    if (top > img_h) top = img_h;
    bottom = top + fh;
    if (bottom > img_h) bottom = img_h;
    span = (halo_r < MAX_HALO) ? halo_r : MAX_HALO;
    for (int y = top; y < bottom; y++)
      for (int x = 0; x < img_w; x++) begin
        idx = y * img_w + x;
        if (idx >= STORE_DEPTH) continue;
        if (pix_mem[idx][23:0] == key_rgb) pix_mem[idx][31:24] = 8'd0;
        else if (span != 0) src[idx] = 1'b1;
      end
    if (span == 0) return;
    for (int y = top; y < bottom; y++)
      for (int x = 0; x < img_w; x++) begin
        idx = y * img_w + x;
        if (idx >= STORE_DEPTH || !src.exists(idx)) continue;
        xs = (x - span < 0) ? 0 : x - span;
        xf = (x + span + 1 > img_w) ? img_w : x + span + 1;
        ys = (y - span < top) ? top : y - span;
        yf = (y + span + 1 > bottom) ? bottom : y + span + 1;
        for (int tx = xs; tx < xf; tx++)
          for (int ty = ys; ty < yf; ty++) begin
            dx = (x > tx) ? x - tx : tx - x;
            dy = (y > ty) ? y - ty : ty - y;
            dv = 1 + 2 * span - dx - dy;
            t = ty * img_w + tx;
            if (t >= STORE_DEPTH) continue;
            a = pix_mem[t][31:24];
            if (a == 255) continue;
            a += halo_inc / dv;
            if (a > 255) a = 255;
            pix_mem[t][31:24] = a[7:0];
          end
      end
  endtask

  // Offer one item, hold it until accepted, then predict its result
  task automatic send_item(logic [1:0] c, logic [17:0] ix, logic [7:0] r, g, b, a,
                           bit typed, pix_res_t typed_res);
    pix_res_t res;
    if ($urandom_range(0, 99) < snd_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= c;
    in_pixel_index <= ix;
    in_red_in <= r;
    in_green_in <= g;
    in_blue_in <= b;
    in_alpha_in <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = '0;
    case (c)
      CMD_LOAD: begin
        pix_mem[ix] = {a, r, g, b};
        if (!written.exists(ix)) begin
          written[ix] = 1'b1;
          written_q = {written_q, int'(ix)};
        end
      end
      CMD_PROC: begin
        process_band();
        res.done = 1'b1;
      end
      CMD_READ: res = '{pix_mem[ix][23:16], pix_mem[ix][15:8], pix_mem[ix][7:0],
                        pix_mem[ix][31:24], 1'b0};
      default: ;
    endcase
    if (c == CMD_PROC || c == CMD_READ) pending_q = {pending_q, typed ? typed_res : res};
  endtask

  // Wait for all results and for any load still in work
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] ri, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {ri, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (ri)
      REG_KEY:   key_rgb = v[23:0];
      REG_HALO:  halo_r = v[3:0];
      REG_INC:   halo_inc = v[15:0];
      REG_WIDTH: img_w = v[9:0];
      REG_HGT:   img_h = v[9:0];
      REG_NFRM:  n_bands = v[9:0];
      REG_FIDX:  band_sel = v[8:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(logic [23:0] k, int hr, inc, w, h, nf, fi);
    write_reg(REG_KEY, k);
    write_reg(REG_HALO, hr);
    write_reg(REG_INC, inc);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HGT, h);
    write_reg(REG_NFRM, nf);
    write_reg(REG_FIDX, fi);
  endtask

  // Load a pixel with random colour, often the key colour
  task automatic load_rand(int ix);
    logic [23:0] rgb;
    logic [7:0] a;
    rgb = ($urandom_range(0, 2) == 0) ? key_rgb : 24'($urandom);
    case ($urandom_range(0, 3))
      0: a = 8'd0;
      1: a = 8'd255;
      default: a = 8'($urandom);
    endcase
    send_item(CMD_LOAD, ix, rgb[23:16], rgb[15:8], rgb[7:0], a, 1'b0, '0);
  endtask

  stim_row_t dir_tab [14];

  initial begin
    int fh, top, bottom, nrand;
    int w, h, nf, fi, hr, inc;
    logic [23:0] k;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; in_cmd = CMD_LOAD; in_pixel_index = '0;
    in_red_in = '0; in_green_in = '0; in_blue_in = '0; in_alpha_in = '0;
    out_ready = 1'b0; rst_n = 1'b0;
    err_cnt = 0; cycles = 0; hold_req = 0; hold_seen = 0; hold_cnt = 0;
    key_rgb = '0; halo_r = '0; halo_inc = '0;
    img_w = 320; img_h = 200; n_bands = 1; band_sel = 0;
    snd_pct = 19; rcv_pct = 50;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 3x2 image, key 112233, no halo
    set_geometry(24'h112233, 0, 0, 3, 2, 1, 0);
    dir_tab = '{
      '{CMD_LOAD, 18'd0, 8'h11, 8'h22, 8'h33, 8'h80, 1'b0, '0},
      '{CMD_LOAD, 18'd1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0},
      '{CMD_LOAD, 18'd2, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
      '{CMD_LOAD, 18'd3, 8'h11, 8'h22, 8'h33, 8'hFF, 1'b0, '0},
      '{CMD_LOAD, 18'd4, 8'h5A, 8'hA5, 8'h3C, 8'h7F, 1'b0, '0},
      '{CMD_LOAD, 18'd5, 8'h11, 8'h22, 8'h34, 8'h01, 1'b0, '0},
      '{CMD_LOAD, 18'h3FFFF, 8'hAA, 8'h55, 8'hC3, 8'hFE, 1'b0, '0},
      '{CMD_READ, 18'd1, '0, '0, '0, '0, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0}},
      '{CMD_READ, 18'h3FFFF, '0, '0, '0, '0, 1'b1, '{8'hAA, 8'h55, 8'hC3, 8'hFE, 1'b0}},
      '{CMD_UNUSED, 18'd4, 8'h01, 8'h02, 8'h03, 8'h04, 1'b0, '0},
      '{CMD_PROC, 18'd0, '0, '0, '0, '0, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1}},
      '{CMD_READ, 18'd0, '0, '0, '0, '0, 1'b1, '{8'h11, 8'h22, 8'h33, 8'h00, 1'b0}},
      '{CMD_READ, 18'd3, '0, '0, '0, '0, 1'b1, '{8'h11, 8'h22, 8'h33, 8'h00, 1'b0}},
      '{CMD_READ, 18'd5, '0, '0, '0, '0, 1'b0, '0}
    };
    foreach (dir_tab[i])
      send_item(dir_tab[i].cmd, dir_tab[i].idx, dir_tab[i].r, dir_tab[i].g,
                dir_tab[i].b, dir_tab[i].a, dir_tab[i].typed, dir_tab[i].res);
    drain();

    // Random phases, extremes of the geometry first
    for (int p = 0; p < 9; p++) begin
      if (p == 3) begin snd_pct = 50; rcv_pct = 19; end
      if (p == 6) begin snd_pct = 0; rcv_pct = 0; end
      k = 24'($urandom); hr = $urandom_range(0, 15); inc = $urandom_range(0, 65535);
      w = $urandom_range(1, 12); h = $urandom_range(1, 12);
      nf = $urandom_range(1, h); fi = $urandom_range(0, nf - 1);
      case (p)
        0: begin w = 4; h = 6; nf = 2; fi = 1; hr = 1; inc = 300; end
        1: begin w = 1; h = 1; nf = 1; fi = 0; hr = 15; inc = 65535; k = 24'hFFFFFF; end
        2: begin w = 8; h = 8; nf = 4; fi = 3; hr = 2; inc = 0; k = 24'h000000; end
        3: begin w = 256; h = 512; nf = 512; fi = 511; hr = 3; end
        4: begin nf = 0; fi = 0; end
        5: begin nf = 1; fi = 511; end
        6: begin w = 0; end
        default: ;
      endcase
      set_geometry(k, hr, inc, w, h, nf, fi);
      fh = (n_bands != 0) ? img_h / n_bands : 0;
      top = band_sel * fh;
      if (top > img_h) top = img_h;
      bottom = (top + fh > img_h) ? img_h : top + fh;
      if (written_q.size() == 0) load_rand($urandom_range(0, STORE_DEPTH - 1));
      for (int y = top; y < bottom; y++)
        for (int x = 0; x < img_w; x++) load_rand(y * img_w + x);
      if (p == 0) hold_req++;
      nrand = 40;
      for (int n = 0; n < nrand; n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            if (bottom > top && img_w > 0)
              load_rand($urandom_range(top, bottom - 1) * img_w +
                        $urandom_range(0, img_w - 1));
            else load_rand($urandom_range(0, STORE_DEPTH - 1));
          end
          3: load_rand($urandom_range(0, STORE_DEPTH - 1));
          4: send_item(CMD_UNUSED, 18'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom), 1'b0, '0);
          5: send_item(CMD_PROC, 18'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom), 1'b0, '0);
          default: send_item(CMD_READ,
                             written_q[$urandom_range(0, written_q.size() - 1)],
                             8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                             1'b0, '0);
        endcase
      end
      // Close the phase: process once more and read back up to 4 rows and 8 columns of the band
      send_item(CMD_PROC, '0, '0, '0, '0, '0, 1'b0, '0);
      for (int y = top; y < bottom && y < top + 4; y++)
        for (int x = 0; x < img_w && x < 8; x++)
          send_item(CMD_READ, y * img_w + x, '0, '0, '0, '0, 1'b0, '0);
      drain();
    end

    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("color_key_alpha_with_halo_top_tb: clean");
    end else begin
      $display("color_key_alpha_with_halo_top_tb: errors");
    end
    $finish;
  end

endmodule
